// ===== design/piecewise_linear_profile_lookup_top_defines.svh =====
// Assertion macros shared by the profile lookup RTL.
`ifndef PIECEWISE_LINEAR_PROFILE_LOOKUP_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_PROFILE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PWL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwl: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwl: assertion failed");

`endif

// ===== design/pwl_pkg.sv =====
// Types and constants for the piecewise-linear profile lookup.
package pwl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int PROFILES_DEF   = 3;
    localparam int LEN_REGS       = 3;
    localparam int LEN_W          = 7;
    localparam int DATA_W         = 32;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN0 = 2'd0,
        CFG_LEN1 = 2'd1,
        CFG_LEN2 = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                     kind;
        logic [1:0]               profile;
        logic [5:0]               point_index;
        logic signed [DATA_W-1:0] point_abscissa;
        logic signed [DATA_W-1:0] point_value;
        logic signed [DATA_W-1:0] height;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     degenerate;
    } res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_status_t;

endpackage

// ===== design/pwl_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/pwl_muldiv.sv =====
// Serial unsigned multiply (33x33) then restoring divide, quotient clamped to 2^34.
`include "piecewise_linear_profile_lookup_top_defines.svh"
module pwl_muldiv import pwl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] m1,
    input  logic [32:0] m2,
    input  logic [32:0] m3,
    output logic [34:0] q,
    output md_status_t  status
);

    localparam int MUL_STEPS = 33;
    localparam int DIV_STEPS = 65;
    localparam logic [34:0] Q_MAX = 35'h4_0000_0000;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_MUL  = 4'b0010,
        PH_DIV  = 4'b0100,
        PH_FIN  = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [66:0] p_reg, p_next;
    logic [32:0] m1_reg, m1_next;
    logic [32:0] d_reg, d_next;
    logic [32:0] r_reg, r_next;
    logic [64:0] quo_reg, quo_next;

    logic [34:0] mul_sum;
    logic [33:0] div_trial;
    logic        div_ge;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        p_next     = p_reg;
        m1_next    = m1_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        quo_next   = quo_reg;
        mul_sum    = {1'b0, p_reg[66:33]} + (p_reg[0] ? {2'b00, m1_reg} : 35'd0);
        div_trial  = {r_reg, quo_reg[64]};
        div_ge     = div_trial >= {1'b0, d_reg};

        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    p_next     = {34'd0, m2};
                    m1_next    = m1;
                    d_next     = m3;
                    cnt_next   = '0;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                p_next   = {mul_sum, p_reg[32:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(MUL_STEPS - 1))
                begin
                    quo_next   = p_next[64:0];
                    r_next     = '0;
                    cnt_next   = '0;
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                r_next   = div_ge ? 33'(div_trial - {1'b0, d_reg}) : div_trial[32:0];
                quo_next = {quo_reg[63:0], div_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    phase_next = PH_FIN;
                end
            end
            PH_FIN:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        m1_reg  <= m1_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        quo_reg <= quo_next;
    end

    assign q           = (quo_reg > 65'(Q_MAX)) ? Q_MAX : quo_reg[34:0];
    assign status.busy = phase_reg != PH_IDLE;
    assign status.done = phase_reg == PH_FIN;

    `PWL_ASSERT_IMPL(a_md_divisor_nonzero, start && phase_reg == PH_IDLE, m3 != 33'd0)
    `PWL_ASSERT_NEXT(a_md_fin_after_div, phase_reg == PH_DIV && cnt_reg == 7'(DIV_STEPS - 1), status.done)

endmodule

// ===== design/piecewise_linear_profile_lookup_top.sv =====
// Top level: breakpoint tables, segment walk sequencer and result register.
//
// Requests arrive on req_valid/req_stall/req_data. A write request stores one
// breakpoint and produces no result; a query request produces one result on
// res_valid/res_stall/res_data. Lengths are set through cfg_valid/cfg_ready,
// cfg_index selects the length register and cfg_data carries the count.
// A write leaves the sequencer idle. A query over an empty table or a
// one-point table goes straight to its result. Otherwise a query steps
// over at most 62 segments for 64 points, one table read per step on the
// registered memory port, then runs the serial multiplier and the
// restoring divider. A segment with equal abscissas skips the arithmetic.
// One request is worked on at a time; req_stall is high while it runs.
// The result register lets the next request start while a result waits;
// a query that finishes while the receiver stalls holds until it is free.
// Reset clears the length registers, so every table reads as empty; the
// table memories are not cleared and must be written before being queried.
`include "piecewise_linear_profile_lookup_top_defines.svh"
module piecewise_linear_profile_lookup_top import pwl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int PROFILES   = PROFILES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    localparam int DEPTH = PROFILES * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD_A = 6'b000010,
        ST_LOAD_B = 6'b000100,
        ST_SETUP  = 6'b001000,
        ST_MATH   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         len0_reg, len1_reg, len2_reg;
    logic [LEN_W-1:0]         n_reg, n_next;
    logic [LEN_W-1:0]         i_reg, i_next;
    logic [AW-1:0]            base_reg, base_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] xa_reg, xa_next, va_reg, va_next;
    logic signed [DATA_W-1:0] xb_reg, xb_next, vb_reg, vb_next;
    res_t                     pend_reg, pend_next;
    logic                     res_valid_reg, res_valid_next;
    res_t                     res_data_reg, res_data_next;

    logic                     accept;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [DATA_W-1:0]        ab_rdata, val_rdata;
    logic [LEN_W-1:0]         len_sel, n_sel;
    logic                     walk_on;

    logic signed [32:0]       dv, dx, dxx;
    logic [32:0]              m1, m2, m3;
    logic                     q_neg;
    logic                     md_start;
    logic [34:0]              md_q;
    md_status_t               md_status;
    logic signed [35:0]       sq;
    logic signed [36:0]       sum;
    logic signed [DATA_W-1:0] sat;

    assign accept    = req_valid && !req_stall;
    assign req_stall = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign ram_we    = accept && req_data.kind == KIND_WRITE
                       && 32'(req_data.profile) < PROFILES
                       && 32'(req_data.point_index) < MAX_POINTS;
    assign ram_waddr = AW'(32'(req_data.profile) * MAX_POINTS + 32'(req_data.point_index));

    pwl_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_abscissa_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_data.point_abscissa),
        .raddr (ram_raddr),
        .rdata (ab_rdata)
    );

    pwl_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_data.point_value),
        .raddr (ram_raddr),
        .rdata (val_rdata)
    );

    // length of the addressed table, clamped
    always_comb
    begin
        len_sel = '0;
        if (32'(req_data.profile) < PROFILES)
        begin
            case (req_data.profile)
                2'd0:    len_sel = len0_reg;
                2'd1:    len_sel = len1_reg;
                2'd2:    len_sel = len2_reg;
                default: len_sel = '0;
            endcase
        end
        n_sel = (32'(len_sel) > MAX_POINTS) ? LEN_W'(MAX_POINTS) : len_sel;
    end

    // segment arithmetic from held endpoints
    assign dv    = {vb_reg[31], vb_reg} - {va_reg[31], va_reg};
    assign dx    = {x_reg[31], x_reg} - {xa_reg[31], xa_reg};
    assign dxx   = {xb_reg[31], xb_reg} - {xa_reg[31], xa_reg};
    assign m1    = dv[32] ? 33'(-dv) : 33'(dv);
    assign m2    = dx[32] ? 33'(-dx) : 33'(dx);
    assign m3    = dxx[32] ? 33'(-dxx) : 33'(dxx);
    assign q_neg = dv[32] ^ dx[32] ^ dxx[32];

    assign sq  = q_neg ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});
    assign sum = {{5{va_reg[31]}}, va_reg} + {sq[35], sq};
    always_comb
    begin
        if (sum > 37'sd2147483647)
        begin
            sat = 32'sh7FFF_FFFF;
        end
        else if (sum < -37'sd2147483648)
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    assign md_start = state_reg == ST_SETUP && xa_reg != xb_reg;

    pwl_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .m1     (m1),
        .m2     (m2),
        .m3     (m3),
        .q      (md_q),
        .status (md_status)
    );

    // step on while i < n-2 and next abscissa <= height
    assign walk_on = (i_reg + LEN_W'(2) < n_reg) && ($signed(ab_rdata) <= x_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        xa_next        = xa_reg;
        va_next        = va_reg;
        xb_next        = xb_reg;
        vb_next        = vb_reg;
        pend_next      = pend_reg;
        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg && res_stall;
        ram_raddr      = base_reg;

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = AW'(32'(req_data.profile) * MAX_POINTS);
                if (accept && req_data.kind == KIND_QUERY)
                begin
                    n_next    = n_sel;
                    x_next    = req_data.height;
                    base_next = AW'(32'(req_data.profile) * MAX_POINTS);
                    if (n_sel == '0)
                    begin
                        pend_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOAD_A;
                    end
                end
            end
            ST_LOAD_A:
            begin
                ram_raddr = AW'(32'(base_reg) + 32'd1);
                xa_next   = ab_rdata;
                va_next   = val_rdata;
                i_next    = '0;
                if (n_reg == LEN_W'(1))
                begin
                    pend_next.result_value = val_rdata;
                    pend_next.degenerate   = 1'b0;
                    state_next             = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOAD_B;
                end
            end
            ST_LOAD_B:
            begin
                ram_raddr = AW'(32'(base_reg) + 32'(i_reg) + 32'd2);
                if (walk_on)
                begin
                    xa_next = ab_rdata;
                    va_next = val_rdata;
                    i_next  = i_reg + LEN_W'(1);
                end
                else
                begin
                    xb_next    = ab_rdata;
                    vb_next    = val_rdata;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (xa_reg == xb_reg)
                begin
                    pend_next.result_value = va_reg;
                    pend_next.degenerate   = 1'b1;
                    state_next             = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MATH;
                end
            end
            ST_MATH:
            begin
                if (md_status.done)
                begin
                    pend_next.result_value = sat;
                    pend_next.degenerate   = 1'b0;
                    state_next             = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_data_next  = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            len0_reg      <= '0;
            len1_reg      <= '0;
            len2_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEN0: len0_reg <= cfg_data;
                    CFG_LEN1: len1_reg <= cfg_data;
                    CFG_LEN2: len2_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        base_reg     <= base_next;
        x_reg        <= x_next;
        xa_reg       <= xa_next;
        va_reg       <= va_next;
        xb_reg       <= xb_next;
        vb_reg       <= vb_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    `PWL_ASSERT_NEXT(a_write_frees_next, accept && req_data.kind == KIND_WRITE, !req_stall)
    `PWL_ASSERT_IMPL(a_result_from_finish, $rose(res_valid_reg), $past(state_reg == ST_FINISH))
    `PWL_ASSERT_IMPL(a_walk_in_range, state_reg == ST_LOAD_B, (8'(i_reg) + 8'd1) < 8'(n_reg))
    `PWL_ASSERT_IMPL(a_start_when_free, md_start, !md_status.busy)

endmodule
